[hw/rtl/pcbp_pkg.sv]
// pcbp_pkg: shared types and constants for the prefix-code bit packer.
// No dependencies.
package pcbp_pkg;

  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int SYM_W  = 8;
  localparam int CMD_W  = 2;
  localparam int ENTRY_W = CODE_W + LEN_W;
  localparam int TABLE_DEPTH = 256;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOOK  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_FLUSH = 4'b1000
  } pcbp_state_t;

endpackage

[hw/rtl/prefix_code_bit_packer_unit.sv]
// prefix_code_bit_packer_unit: prefix-code encoder with MSB-first byte packer.
// Depends on pcbp_pkg and pcbp_ram.
//
//   channel | ports                                              | dir
//   --------+----------------------------------------------------+-----
//   in      | in_valid in_stall in_command in_symbol             | in
//           | in_code_bits in_code_length                        |
//   out     | out_valid out_stall out_byte out_last              | out
//
// Load and ignored commands complete in the idle state. Encode goes through
// the lookup state, then the steps of the shared shifter (up to 5 steps for a
// 32-bit code), each step moving up to 8 bits into the accumulator. Flush emits
// from the flush state, or completes in idle when no bits are pending.
// Reset clears the sequencer, the accumulator and the 256 table valid bits.
// A stalled output word holds the sequencer in its current step.
module prefix_code_bit_packer_unit
  import pcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_bits,
  input  logic [LEN_W-1:0]  in_code_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_last
);

  localparam int LEN_CAP = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
  localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);

  pcbp_state_t state_r, state_nxt;
  logic [TABLE_DEPTH-1:0] vld_r, vld_nxt;
  logic                   hit_r, hit_nxt;
  logic [CODE_W-1:0]      word_r, word_nxt;
  logic [LEN_W-1:0]       rem_r, rem_nxt;
  logic [7:0]             acc_r, acc_nxt;
  logic [2:0]             pend_r, pend_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_byte_r, out_byte_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   accept;
  logic                   slot_free;
  logic                   emit;
  logic [LEN_W-1:0]       len_sat;
  logic [ENTRY_W-1:0]     rd_entry;

  logic [3:0]             space;
  logic [3:0]             take;
  logic [LEN_W-1:0]       rem_new;
  logic [CODE_W-1:0]      chunk32;
  logic [8:0]             mask9;
  logic [7:0]             chunk;
  logic [15:0]            acc16;
  logic [3:0]             fill;
  logic [3:0]             pad;
  logic [15:0]            flush16;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign len_sat   = (in_code_length > LEN_CAP_V) ? LEN_CAP_V : in_code_length;

  pcbp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (accept && (in_command == CMD_LOAD)),
    .waddr(in_symbol),
    .wdata({len_sat, in_code_bits}),
    .re   (accept && (in_command == CMD_ENCODE)),
    .raddr(in_symbol),
    .rdata(rd_entry)
  );

  // shared step unit: moves up to 8 code bits into the accumulator
  always_comb begin
    space   = 4'd8 - {1'b0, pend_r};
    take    = (rem_r < {2'b0, space}) ? rem_r[3:0] : space;
    rem_new = rem_r - {2'b0, take};
    chunk32 = word_r >> rem_new;
    mask9   = (9'd1 << take) - 9'd1;
    chunk   = chunk32[7:0] & mask9[7:0];
    acc16   = ({8'b0, acc_r} << take) | {8'b0, chunk};
    fill    = {1'b0, pend_r} + take;
    pad     = 4'd8 - {1'b0, pend_r};
    flush16 = {8'b0, acc_r} << pad;
  end

  always_comb begin
    state_nxt     = state_r;
    vld_nxt       = vld_r;
    hit_nxt       = hit_r;
    word_nxt      = word_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    emit          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_LOAD: begin
              vld_nxt[in_symbol] = 1'b1;
            end
            CMD_ENCODE: begin
              hit_nxt   = vld_r[in_symbol];
              state_nxt = ST_LOOK;
            end
            CMD_FLUSH: begin
              if (pend_r != 3'd0) begin
                state_nxt = ST_FLUSH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOK: begin
        word_nxt  = rd_entry[CODE_W-1:0];
        rem_nxt   = hit_r ? rd_entry[ENTRY_W-1:CODE_W] : '0;
        state_nxt = (hit_r && (rd_entry[ENTRY_W-1:CODE_W] != '0)) ? ST_SHIFT : ST_IDLE;
      end
      ST_SHIFT: begin
        if (slot_free) begin
          rem_nxt = rem_new;
          if (fill == 4'd8) begin
            emit          = 1'b1;
            out_valid_nxt = 1'b1;
            out_byte_nxt  = acc16[7:0];
            out_last_nxt  = (rem_new < LEN_W'(8));
            acc_nxt       = 8'd0;
            pend_nxt      = 3'd0;
          end else begin
            acc_nxt  = acc16[7:0];
            pend_nxt = fill[2:0];
          end
          if (rem_new == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          emit          = 1'b1;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = flush16[7:0];
          out_last_nxt  = 1'b1;
          acc_nxt       = 8'd0;
          pend_nxt      = 3'd0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      acc_r       <= 8'd0;
      pend_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      acc_r       <= acc_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r      <= hit_nxt;
    word_r     <= word_nxt;
    rem_r      <= rem_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  a_shift_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (rem_r != '0 && rem_r <= LEN_CAP_V))
    else $error("shift step with out-of-range remaining count");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> slot_free)
    else $error("word emitted while output register occupied");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && slot_free) |=> (pend_r == 3'd0 && state_r == ST_IDLE))
    else $error("flush left pending bits");

  a_emit_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && emit) |=> (pend_r == 3'd0 && out_valid_r))
    else $error("emitted word did not reach output");

endmodule

[hw/rtl/pcbp_ram.sv]
// pcbp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
